// ===== hdl/bap_pkg.sv =====
package bap_pkg;

    localparam int DATA_W      = 16;
    localparam int PCT_W       = 7;
    localparam int SCALE_W     = 23;
    localparam int DIVISOR_W   = 16;
    localparam int CFG_IDX_W   = 8;

    localparam logic [PCT_W-1:0]     PCT_FULL = 7'd100;
    localparam logic [PCT_W-1:0]     PCT_LOW  = 7'd10;

    localparam logic [DATA_W-1:0]    RESET_EMPTY_MV = 16'd3000;
    localparam logic [DATA_W-1:0]    RESET_FULL_MV  = 16'd4100;

    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MV = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_MV  = 8'd1;

    typedef struct packed {
        logic in_load;
        logic sum_update;
        logic div_start;
        logic div_sel_pct;
        logic avg_load;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ===== hdl/bap_div.sv =====
module bap_div #(
    parameter int DVD_W = 23,
    parameter int DVS_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DVD_W-1:0] quotient,
    output logic             done
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quot_reg;
    logic [DVD_W-1:0] quot_next;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   trial_diff;
    logic             trial_ge;

    assign trial      = {rem_reg, quot_reg[DVD_W-1]};
    assign trial_ge   = trial >= {1'b0, dvs_reg};
    assign trial_diff = trial - {1'b0, dvs_reg};

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[DVD_W-2:0], trial_ge};
            rem_next  = trial_ge ? trial_diff[DVS_W-1:0] : trial[DVS_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign quotient = quot_reg;
    assign done     = done_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("Divider reported done without having been busy.");

    a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (busy_reg && cnt_reg == CNT_W'(DVD_W)))
        else $error("Divider did not begin a full division after start.");

endmodule

// ===== hdl/bap_datapath.sv =====
module bap_datapath #(
    parameter int WINDOW_DEPTH = 100
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bap_pkg::ctrl_cmd_t            cmd,
    output bap_pkg::ctrl_sts_t            sts,
    input  logic                          cfg_valid,
    input  logic [bap_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bap_pkg::DATA_W-1:0]    cfg_data,
    input  logic [bap_pkg::DATA_W-1:0]    sample,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [23:0]                   m_tdata
);

    import bap_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = DATA_W + $clog2(WINDOW_DEPTH);
    localparam int DVD_W = (SUM_W > SCALE_W) ? SUM_W : SCALE_W;
    localparam int DVS_W_T = DIVISOR_W;

    logic [DATA_W-1:0] ring_mem [WINDOW_DEPTH];

    logic [DATA_W-1:0]  empty_reg;
    logic [DATA_W-1:0]  full_reg;
    logic [IDX_W-1:0]   slot_reg;
    logic [IDX_W-1:0]   slot_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [DATA_W-1:0]  sample_reg;
    logic [DATA_W-1:0]  rd_data_reg;
    logic [DATA_W-1:0]  avg_reg;
    logic [SCALE_W-1:0] scaled_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [DATA_W-1:0]  out_avg_reg;
    logic [PCT_W-1:0]   out_pct_reg;
    logic               out_low_reg;

    logic               ring_full;
    logic [DATA_W-1:0]  old_sample;
    logic [DATA_W-1:0]  avg_q;
    logic [DATA_W-1:0]  avg_hi;
    logic [DATA_W-1:0]  avg_clamped;
    logic [DATA_W-1:0]  avg_offset;
    logic [SCALE_W-1:0] scaled_value;
    logic               range_ok;
    logic [PCT_W-1:0]   pct_value;
    logic [DVD_W-1:0]   div_dividend;
    logic [DVS_W_T-1:0] div_divisor;
    logic [DVD_W-1:0]   div_quotient;
    logic               div_done;

    // Entries past the fill point were never written; until the ring is full the outgoing sample is taken as zero.
    assign ring_full  = count_reg == CNT_W'(WINDOW_DEPTH);
    assign old_sample = ring_full ? rd_data_reg : '0;

    always_comb
    begin
        sum_next   = sum_reg;
        slot_next  = slot_reg;
        count_next = count_reg;
        if (cmd.sum_update)
        begin
            sum_next = sum_reg - SUM_W'(old_sample) + SUM_W'(sample_reg);
            if (slot_reg == IDX_W'(WINDOW_DEPTH - 1))
            begin
                slot_next = '0;
            end
            else
            begin
                slot_next = slot_reg + 1'b1;
            end
            if (!ring_full)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_reg <= RESET_EMPTY_MV;
            full_reg  <= RESET_FULL_MV;
            slot_reg  <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_index == REG_EMPTY_MV)
            begin
                empty_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == REG_FULL_MV)
            begin
                full_reg <= cfg_data;
            end
            slot_reg  <= slot_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            sample_reg  <= sample;
            rd_data_reg <= ring_mem[slot_reg];
        end
        if (cmd.sum_update)
        begin
            ring_mem[slot_reg] <= sample_reg;
        end
    end

    assign div_dividend = cmd.div_sel_pct ? DVD_W'(scaled_reg) : DVD_W'(sum_reg);
    assign div_divisor  = cmd.div_sel_pct ? (full_reg - empty_reg) : DVS_W_T'(count_reg);

    bap_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W_T)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    // The mean is limited to the full level first and then raised to the empty level.
    assign avg_q        = div_quotient[DATA_W-1:0];
    assign avg_hi       = (avg_q > full_reg) ? full_reg : avg_q;
    assign avg_clamped  = (avg_hi < empty_reg) ? empty_reg : avg_hi;
    assign avg_offset   = avg_clamped - empty_reg;
    assign scaled_value = SCALE_W'(avg_offset) * SCALE_W'(PCT_FULL);
    assign range_ok     = full_reg > empty_reg;
    assign pct_value    = range_ok ? div_quotient[PCT_W-1:0] : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.avg_load)
        begin
            avg_reg    <= avg_q;
            scaled_reg <= scaled_value;
        end
        if (cmd.out_load)
        begin
            out_avg_reg <= avg_reg;
            out_pct_reg <= pct_value;
            out_low_reg <= pct_value <= PCT_LOW;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_low_reg, out_pct_reg, out_avg_reg};

    a_slot_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
        !ring_full |-> (CNT_W'(slot_reg) == count_reg))
        else $error("Write slot and fill count disagree while the ring fills.");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sum_update |=> (count_reg != '0))
        else $error("Fill count is zero after an update.");

    a_low_matches_pct: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_low_reg == (out_pct_reg <= PCT_LOW)))
        else $error("Low-charge flag does not match the percentage.");

endmodule

// ===== hdl/bap_ctrl.sv =====
module bap_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  bap_pkg::ctrl_sts_t  sts,
    output bap_pkg::ctrl_cmd_t  cmd
);

    import bap_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_DIV_AVG,
        S_WAIT_AVG,
        S_DIV_PCT,
        S_WAIT_PCT,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.in_load = 1'b1;
                    state_next  = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.sum_update = 1'b1;
                state_next     = S_DIV_AVG;
            end
            S_DIV_AVG:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT_AVG;
            end
            S_WAIT_AVG:
            begin
                if (sts.div_done)
                begin
                    cmd.avg_load = 1'b1;
                    state_next   = S_DIV_PCT;
                end
            end
            S_DIV_PCT:
            begin
                cmd.div_start   = 1'b1;
                cmd.div_sel_pct = 1'b1;
                state_next      = S_WAIT_PCT;
            end
            S_WAIT_PCT:
            begin
                if (sts.div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                cmd.div_sel_pct = 1'b1;
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("Result loaded while the output register was still occupied.");

endmodule

// ===== hdl/battery_average_percent_top.sv =====
// Battery voltage averager: each sample item (millivolts) enters a ring of WINDOW_DEPTH
// entries and a running sum; the result item carries the truncated mean (divided by the
// number of samples seen until the ring is full), a 0..100 charge percentage between the
// empty and full levels, and a low-charge flag set at 10 percent or below. The single
// divider, W = max(16 + clog2(WINDOW_DEPTH), 23) bits wide, retires one quotient bit per
// cycle and runs twice per item. A new item is accepted only once the previous one has
// reached the output register, so acceptance also waits while a result waits on the output.
// The ring needs no clearing after reset.
module battery_average_percent_top #(
    parameter int WINDOW_DEPTH = 100
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,    // [15:0] sample_millivolts
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,    // [15:0] average_millivolts,
                                                      // [22:16] charge_percent,
                                                      // [23] low_charge
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bap_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bap_pkg::DATA_W-1:0]    cfg_data
);

    import bap_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    assign cfg_ready = 1'b1;

    bap_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bap_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (s_tdata[DATA_W-1:0]),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule
